/* src/operand_addressing_unit_core_defines.svh */
// assertion helpers shared by the operand access unit
`ifndef OPERAND_ADDRESSING_UNIT_CORE_DEFINES_SVH
`define OPERAND_ADDRESSING_UNIT_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// implication checked on every clock edge outside reset
`define OAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define OAU_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define OAU_ASSERT(label, prop, msg)

`define OAU_ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* src/oau_pkg.sv */
`default_nettype none

package oau_pkg;

  localparam int NUM_REGS    = 16;
  localparam int MEM_WORDS   = 256;
  localparam int REG_AW      = $clog2(NUM_REGS);
  localparam int MEM_AW      = $clog2(MEM_WORDS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int DATA_W  = 32;
  localparam int LIT_W   = 11;
  localparam int OPND_W  = 8;
  localparam int MODE_W  = 4;
  localparam int TDATA_W = 64;
  localparam int TUSER_W = 2;

  localparam logic [LIT_W-1:0] LIT_SIGN_BIT = 11'd1024;
  localparam logic [LIT_W-1:0] LIT_MAG_MASK = 11'd1023;

  localparam logic [MODE_W-1:0] MODE_REG        = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LIT        = 4'd1;
  localparam logic [MODE_W-1:0] MODE_DIR        = 4'd2;
  localparam logic [MODE_W-1:0] MODE_IND        = 4'd3;
  localparam logic [MODE_W-1:0] MODE_IDX_LIT    = 4'd4;
  localparam logic [MODE_W-1:0] MODE_IDX_REG    = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NONE       = 4'd6;
  localparam logic [MODE_W-1:0] MODE_RAW        = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MDIR       = 4'd8;
  localparam logic [MODE_W-1:0] MODE_MIND       = 4'd9;
  localparam logic [MODE_W-1:0] MODE_MIDX_LIT   = 4'd10;
  localparam logic [MODE_W-1:0] MODE_MIDX_REG   = 4'd11;
  localparam logic [MODE_W-1:0] MODE_MDIR2      = 4'd12;
  localparam logic [MODE_W-1:0] MODE_MIND2      = 4'd13;
  localparam logic [MODE_W-1:0] MODE_MIDX_OP    = 4'd14;
  localparam logic [MODE_W-1:0] MODE_MIDX_OPREG = 4'd15;

  typedef enum logic [1:0] {
    KIND_SRC_RD = 2'd0,
    KIND_DST_RD = 2'd1,
    KIND_DST_WR = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_IMM,
    ACT_REG,
    ACT_REG_WR,
    ACT_MEM_RD,
    ACT_MEM_WR
  } action_t;

  typedef enum logic [1:0] {
    OFF_NONE,
    OFF_IMM,
    OFF_REG
  } off_sel_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ADDR,
    B_MEM
  } back_state_t;

  typedef struct packed {
    action_t             action;
    logic                base_reg;
    off_sel_t            off_sel;
    logic [REG_AW-1:0]   reg_a;
    logic [REG_AW-1:0]   reg_b;
    logic [LIT_W-1:0]    off_imm;
    logic [DATA_W-1:0]   imm;
    logic [DATA_W-1:0]   wdata;
  } cmd_t;

  function automatic logic [REG_AW-1:0] reg_idx(input logic [LIT_W-1:0] v);
    return REG_AW'(v % NUM_REGS);
  endfunction

  function automatic logic [MEM_AW-1:0] mem_idx(input logic [DATA_W-1:0] a);
    return MEM_AW'(a % MEM_WORDS);
  endfunction

endpackage

`default_nettype wire

/* src/oau_ram.sv */
`default_nettype none

module oau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/oau_front.sv */
`default_nettype none

module oau_front (
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [oau_pkg::TDATA_W-1:0]   s_tdata,
  input  wire logic [oau_pkg::TUSER_W-1:0]   s_tuser,
  input  wire logic                          q_full,
  output      logic                          push,
  output      oau_pkg::cmd_t                 cmd
);

  logic [oau_pkg::OPND_W-1:0] op1;
  logic [oau_pkg::OPND_W-1:0] op2;
  logic [oau_pkg::LIT_W-1:0]  lit;
  logic [oau_pkg::MODE_W-1:0] mode;
  logic [oau_pkg::DATA_W-1:0] wdata;
  logic [oau_pkg::LIT_W-1:0]  op1_ext;
  logic [oau_pkg::LIT_W-1:0]  op2_ext;
  logic [oau_pkg::DATA_W-1:0] lit_mag;
  logic [oau_pkg::DATA_W-1:0] lit_val;
  oau_pkg::kind_t             kind;
  oau_pkg::action_t           mem_act;

  assign op1   = s_tdata[7:0];
  assign op2   = s_tdata[15:8];
  assign lit   = s_tdata[26:16];
  assign mode  = s_tdata[30:27];
  assign wdata = s_tdata[62:31];
  assign kind  = oau_pkg::kind_t'(s_tuser);

  assign op1_ext = oau_pkg::LIT_W'(op1);
  assign op2_ext = oau_pkg::LIT_W'(op2);

  // sign-magnitude literal, negative zero reads as zero
  assign lit_mag = oau_pkg::DATA_W'(lit & oau_pkg::LIT_MAG_MASK);
  assign lit_val = ((lit & oau_pkg::LIT_SIGN_BIT) != '0) ? (32'd0 - lit_mag) : lit_mag;

  assign mem_act = (kind == oau_pkg::KIND_DST_WR) ? oau_pkg::ACT_MEM_WR : oau_pkg::ACT_MEM_RD;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd          = '0;
    cmd.action   = oau_pkg::ACT_IMM;
    cmd.base_reg = 1'b0;
    cmd.off_sel  = oau_pkg::OFF_NONE;
    cmd.reg_a    = oau_pkg::reg_idx(op1_ext);
    cmd.reg_b    = oau_pkg::reg_idx(lit);
    cmd.off_imm  = lit;
    cmd.imm      = '0;
    cmd.wdata    = wdata;
    unique case (kind)
      oau_pkg::KIND_SRC_RD: begin
        cmd.reg_a = oau_pkg::reg_idx(op2_ext);
        unique case (mode)
          oau_pkg::MODE_REG, oau_pkg::MODE_MDIR, oau_pkg::MODE_MIND,
          oau_pkg::MODE_MIDX_LIT, oau_pkg::MODE_MIDX_REG: begin
            cmd.action = oau_pkg::ACT_REG;
          end
          oau_pkg::MODE_LIT, oau_pkg::MODE_MDIR2, oau_pkg::MODE_MIND2,
          oau_pkg::MODE_MIDX_OP, oau_pkg::MODE_MIDX_OPREG: begin
            cmd.imm = lit_val;
          end
          oau_pkg::MODE_DIR: begin
            cmd.action = oau_pkg::ACT_MEM_RD;
            cmd.imm    = oau_pkg::DATA_W'(op2);
          end
          oau_pkg::MODE_IND: begin
            cmd.action   = oau_pkg::ACT_MEM_RD;
            cmd.base_reg = 1'b1;
          end
          oau_pkg::MODE_IDX_LIT: begin
            cmd.action   = oau_pkg::ACT_MEM_RD;
            cmd.base_reg = 1'b1;
            cmd.off_sel  = oau_pkg::OFF_IMM;
          end
          oau_pkg::MODE_IDX_REG: begin
            cmd.action   = oau_pkg::ACT_MEM_RD;
            cmd.base_reg = 1'b1;
            cmd.off_sel  = oau_pkg::OFF_REG;
          end
          default: begin
            cmd.imm = '0;
          end
        endcase
      end
      oau_pkg::KIND_DST_RD, oau_pkg::KIND_DST_WR: begin
        unique case (mode)
          oau_pkg::MODE_REG, oau_pkg::MODE_LIT, oau_pkg::MODE_DIR,
          oau_pkg::MODE_IND, oau_pkg::MODE_IDX_LIT, oau_pkg::MODE_IDX_REG: begin
            cmd.action = (kind == oau_pkg::KIND_DST_WR) ? oau_pkg::ACT_REG_WR
                                                         : oau_pkg::ACT_REG;
          end
          oau_pkg::MODE_RAW: begin
            cmd.imm = (kind == oau_pkg::KIND_DST_WR) ? '0 : oau_pkg::DATA_W'(lit);
          end
          oau_pkg::MODE_MDIR, oau_pkg::MODE_MDIR2: begin
            cmd.action = mem_act;
            cmd.imm    = oau_pkg::DATA_W'(op1);
          end
          oau_pkg::MODE_MIND, oau_pkg::MODE_MIND2: begin
            cmd.action   = mem_act;
            cmd.base_reg = 1'b1;
          end
          oau_pkg::MODE_MIDX_LIT: begin
            cmd.action   = mem_act;
            cmd.base_reg = 1'b1;
            cmd.off_sel  = oau_pkg::OFF_IMM;
          end
          oau_pkg::MODE_MIDX_REG: begin
            cmd.action   = mem_act;
            cmd.base_reg = 1'b1;
            cmd.off_sel  = oau_pkg::OFF_REG;
          end
          oau_pkg::MODE_MIDX_OP: begin
            cmd.action   = mem_act;
            cmd.base_reg = 1'b1;
            cmd.off_sel  = oau_pkg::OFF_IMM;
            cmd.off_imm  = op2_ext;
          end
          oau_pkg::MODE_MIDX_OPREG: begin
            cmd.action   = mem_act;
            cmd.base_reg = 1'b1;
            cmd.off_sel  = oau_pkg::OFF_REG;
            cmd.reg_b    = oau_pkg::reg_idx(op2_ext);
          end
          default: begin
            cmd.imm = '0;
          end
        endcase
      end
      oau_pkg::KIND_NOP: begin
        cmd.imm = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/oau_cmd_queue.sv */
`default_nettype none

`include "operand_addressing_unit_core_defines.svh"

module oau_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire oau_pkg::cmd_t push_cmd,
  output      logic          full,
  input  wire logic          pop,
  output      logic          not_empty,
  output      oau_pkg::cmd_t head
);

  oau_pkg::cmd_t                 slots [oau_pkg::QUEUE_DEPTH];
  logic [oau_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [oau_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [oau_pkg::QUEUE_AW:0]    count;
  logic [oau_pkg::QUEUE_AW-1:0]  wr_ptr_next;
  logic [oau_pkg::QUEUE_AW-1:0]  rd_ptr_next;
  logic [oau_pkg::QUEUE_AW:0]    count_next;
  logic                          do_pop;

  assign full      = (count == (oau_pkg::QUEUE_AW + 1)'(oau_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    if (push) begin
      wr_ptr_next = (wr_ptr == oau_pkg::QUEUE_AW'(oau_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_next = (rd_ptr == oau_pkg::QUEUE_AW'(oau_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    count_next = count + (oau_pkg::QUEUE_AW + 1)'(push) - (oau_pkg::QUEUE_AW + 1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  `OAU_ASSERT_NEVER(a_q_overflow, count > (oau_pkg::QUEUE_AW + 1)'(oau_pkg::QUEUE_DEPTH), "queue count above depth")

endmodule

`default_nettype wire

/* src/oau_back.sv */
`default_nettype none

`include "operand_addressing_unit_core_defines.svh"

module oau_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_not_empty,
  input  wire oau_pkg::cmd_t               q_head,
  output      logic                        q_pop,
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [oau_pkg::DATA_W-1:0]  m_tdata
);

  oau_pkg::back_state_t state;
  oau_pkg::back_state_t state_next;
  oau_pkg::cmd_t        cmd;

  logic [oau_pkg::NUM_REGS-1:0]  reg_vld;
  logic [oau_pkg::MEM_WORDS-1:0] mem_vld;
  logic                          reg_a_vld;
  logic                          reg_b_vld;
  logic                          mem_rd_vld;

  logic [oau_pkg::DATA_W-1:0] rf_a_rdata;
  logic [oau_pkg::DATA_W-1:0] rf_b_rdata;
  logic [oau_pkg::DATA_W-1:0] mem_rdata;
  logic [oau_pkg::DATA_W-1:0] reg_a_val;
  logic [oau_pkg::DATA_W-1:0] reg_b_val;
  logic [oau_pkg::DATA_W-1:0] base;
  logic [oau_pkg::DATA_W-1:0] offset;
  logic [oau_pkg::DATA_W-1:0] addr;
  logic [oau_pkg::MEM_AW-1:0] mem_addr;
  logic [oau_pkg::DATA_W-1:0] early_result;
  logic [oau_pkg::DATA_W-1:0] out_data;

  logic out_free;
  logic rf_re;
  logic rf_we;
  logic mem_re;
  logic mem_we;
  logic out_load;
  logic m_tvalid_next;

  assign out_free = !m_tvalid || m_tready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oau_pkg::B_IDLE: begin
        if (q_not_empty) begin
          state_next = oau_pkg::B_ADDR;
        end
      end
      oau_pkg::B_ADDR: begin
        if (cmd.action == oau_pkg::ACT_MEM_RD) begin
          state_next = oau_pkg::B_MEM;
        end else if (out_free) begin
          state_next = oau_pkg::B_IDLE;
        end
      end
      oau_pkg::B_MEM: begin
        if (out_free) begin
          state_next = oau_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = oau_pkg::B_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop    = 1'b0;
    rf_re    = 1'b0;
    rf_we    = 1'b0;
    mem_re   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state)
      oau_pkg::B_IDLE: begin
        q_pop = q_not_empty;
        rf_re = q_not_empty;
      end
      oau_pkg::B_ADDR: begin
        mem_re   = (cmd.action == oau_pkg::ACT_MEM_RD);
        mem_we   = (cmd.action == oau_pkg::ACT_MEM_WR) && out_free;
        rf_we    = (cmd.action == oau_pkg::ACT_REG_WR) && out_free;
        out_load = (cmd.action != oau_pkg::ACT_MEM_RD) && out_free;
      end
      oau_pkg::B_MEM: begin
        out_load = out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // register file, one copy per read port
  oau_ram #(
    .WIDTH(oau_pkg::DATA_W),
    .DEPTH(oau_pkg::NUM_REGS)
  ) u_rf_a (
    .clk  (clk),
    .we   (rf_we),
    .waddr(cmd.reg_a),
    .wdata(cmd.wdata),
    .re   (rf_re),
    .raddr(q_head.reg_a),
    .rdata(rf_a_rdata)
  );

  oau_ram #(
    .WIDTH(oau_pkg::DATA_W),
    .DEPTH(oau_pkg::NUM_REGS)
  ) u_rf_b (
    .clk  (clk),
    .we   (rf_we),
    .waddr(cmd.reg_a),
    .wdata(cmd.wdata),
    .re   (rf_re),
    .raddr(q_head.reg_b),
    .rdata(rf_b_rdata)
  );

  oau_ram #(
    .WIDTH(oau_pkg::DATA_W),
    .DEPTH(oau_pkg::MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_addr),
    .wdata(cmd.wdata),
    .re   (mem_re),
    .raddr(mem_addr),
    .rdata(mem_rdata)
  );

  // address and early result
  assign reg_a_val = reg_a_vld ? rf_a_rdata : '0;
  assign reg_b_val = reg_b_vld ? rf_b_rdata : '0;
  assign base      = cmd.base_reg ? reg_a_val : cmd.imm;

  always_comb begin
    unique case (cmd.off_sel)
      oau_pkg::OFF_IMM: offset = oau_pkg::DATA_W'(cmd.off_imm);
      oau_pkg::OFF_REG: offset = reg_b_val;
      default:          offset = '0;
    endcase
  end

  assign addr     = base + offset;
  assign mem_addr = oau_pkg::mem_idx(addr);

  always_comb begin
    unique case (cmd.action)
      oau_pkg::ACT_IMM: early_result = cmd.imm;
      oau_pkg::ACT_REG: early_result = reg_a_val;
      default:          early_result = '0;
    endcase
  end

  assign out_data      = (state == oau_pkg::B_MEM) ? (mem_rd_vld ? mem_rdata : '0) : early_result;
  assign m_tvalid_next = out_load || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= oau_pkg::B_IDLE;
      m_tvalid <= 1'b0;
      reg_vld  <= '0;
      mem_vld  <= '0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
      if (rf_we) begin
        reg_vld[cmd.reg_a] <= 1'b1;
      end
      if (mem_we) begin
        mem_vld[mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd       <= q_head;
      reg_a_vld <= reg_vld[q_head.reg_a];
      reg_b_vld <= reg_vld[q_head.reg_b];
    end
    if (mem_re) begin
      mem_rd_vld <= mem_vld[mem_addr];
    end
    if (out_load) begin
      m_tdata <= out_data;
    end
  end

  `OAU_ASSERT(a_pop_to_addr, q_pop |=> (state == oau_pkg::B_ADDR), "pop did not start address step")
  `OAU_ASSERT(a_mem_after_read, (state == oau_pkg::B_MEM) |-> ($past(mem_re) || $past(state == oau_pkg::B_MEM)), "memory step without read")
  `OAU_ASSERT(a_write_once, (mem_we || rf_we) |=> (state == oau_pkg::B_IDLE), "write step repeated")
  `OAU_ASSERT_NEVER(a_out_overwrite, out_load && m_tvalid && !m_tready, "pending result overwritten")

endmodule

`default_nettype wire

/* src/operand_addressing_unit_core.sv */
// channel  dir  signals                         contents
// s        in   s_tvalid s_tready s_tdata s_tuser  one operand access
// m        out  m_tvalid m_tready m_tdata          operand value read
//
// memory reads run register file read, address add and memory read in sequence,
// other accesses end after the address add, with no memory read
// a 2-entry queue lets new accesses arrive while the back end is busy
// reset clears all registers and memory words through per-entry valid bits
// a stalled result holds the back end, the front keeps filling the queue
`default_nettype none

module operand_addressing_unit_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  // first_operand, second_operand, literal_field, address_mode, write_data
  input  wire logic [oau_pkg::TDATA_W-1:0]   s_tdata,
  // kind
  input  wire logic [oau_pkg::TUSER_W-1:0]   s_tuser,
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  // read_value
  output      logic [oau_pkg::DATA_W-1:0]    m_tdata
);

  oau_pkg::cmd_t front_cmd;
  oau_pkg::cmd_t head_cmd;
  logic          push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;

  oau_front u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_full  (q_full),
    .push    (push),
    .cmd     (front_cmd)
  );

  oau_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (head_cmd)
  );

  oau_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (head_cmd),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire
